// ===== rtl/bhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Shared sizes, codes, controller/datapath bundles and the key ordering.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int CAPACITY = 128;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CH_W     = IDX_W + 2;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic REG_LARGEST_FIRST = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RD_TARGET = 3'd0,
    RD_LAST   = 3'd1,
    RD_PARENT = 3'd2,
    RD_LEFT   = 3'd3,
    RD_RIGHT  = 3'd4
  } rd_sel_e;

  typedef struct packed {
    logic    load_in;
    logic    set_status;
    status_e status_code;
    logic    push_start;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    start_take;
    logic    take_value;
    logic    take_cur;
    logic    up_move;
    logic    latch_left;
    logic    down_move;
    logic    write_cur;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    empty;
    logic    slot_bad;
    logic    pos_is_last;
    logic    pos_zero;
    logic    left_in_range;
    logic    up_better;
    logic    best_child;
    logic    out_free;
  } stat_t;

  // True when key a belongs strictly above key b in the current order.
  function automatic logic ranks_above(input logic signed [KEY_BITS-1:0] a,
                                       input logic signed [KEY_BITS-1:0] b,
                                       input logic largest);
    logic res;
    res = largest ? (a > b) : (a < b);
    return res;
  endfunction

endpackage

// ===== rtl/bhpq_in_if.sv =====
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one heap operation per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bhpq_in_if;
  import bhpq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            opcode;
  logic signed [KEY_BITS-1:0] key;
  logic [IDX_W-1:0]           slot;

  modport source (output valid, output opcode, output key, output slot, input ready);
  modport sink   (input valid, input opcode, input key, input slot, output ready);
endinterface

// ===== rtl/bhpq_out_if.sv =====
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel carrying one result per operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bhpq_out_if;
  import bhpq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [KEY_BITS-1:0] value;
  logic [STATUS_W-1:0]        status;
  logic [CNT_W-1:0]           count;

  modport source (output valid, output value, output status, output count, input ready);
  modport sink   (input valid, input value, input status, input count, output ready);
endinterface

// ===== rtl/bhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Heap controller
// One-hot sequencer that steps an operation through take, sift and write-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhpq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bhpq_pkg::stat_t stat_i,
  output bhpq_pkg::cmd_t  cmd_o
);
  import bhpq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DISPATCH = 11'b000_0000_0010,
    S_TAKE     = 11'b000_0000_0100,
    S_LAST     = 11'b000_0000_1000,
    S_UP_RD    = 11'b000_0001_0000,
    S_UP_CMP   = 11'b000_0010_0000,
    S_DOWN_RD  = 11'b000_0100_0000,
    S_DOWN_RL  = 11'b000_1000_0000,
    S_DOWN_CMP = 11'b001_0000_0000,
    S_WRITE    = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  // Set for a remove that must fall back to a sift down if it cannot rise.
  logic   allow_down_q, allow_down_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      allow_down_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      allow_down_q <= allow_down_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    allow_down_d = allow_down_q;
    cmd_o        = '0;
    cmd_o.status_code = ST_OK;
    cmd_o.rd_sel      = RD_TARGET;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        allow_down_d = 1'b0;
        unique case (stat_i.op)
          OP_PUSH: begin
            if (stat_i.full) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_FULL;
              state_d           = S_FINISH;
            end else begin
              cmd_o.push_start = 1'b1;
              state_d          = S_UP_RD;
            end
          end
          OP_EXTRACT: begin
            if (stat_i.empty) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_EMPTY;
              state_d           = S_FINISH;
            end else begin
              cmd_o.rd_en      = 1'b1;
              cmd_o.rd_sel     = RD_TARGET;
              cmd_o.start_take = 1'b1;
              state_d          = S_TAKE;
            end
          end
          OP_REMOVE: begin
            if (stat_i.slot_bad) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = ST_RANGE;
              state_d           = S_FINISH;
            end else begin
              cmd_o.rd_en      = 1'b1;
              cmd_o.rd_sel     = RD_TARGET;
              cmd_o.start_take = 1'b1;
              state_d          = S_TAKE;
            end
          end
          OP_NOP: begin
            state_d = S_FINISH;
          end
          default: begin
            state_d = S_FINISH;
          end
        endcase
      end
      S_TAKE: begin
        cmd_o.take_value = 1'b1;
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_sel     = RD_LAST;
        state_d          = stat_i.pos_is_last ? S_FINISH : S_LAST;
      end
      S_LAST: begin
        cmd_o.take_cur = 1'b1;
        if (stat_i.op == OP_REMOVE && !stat_i.pos_zero) begin
          allow_down_d = 1'b1;
          state_d      = S_UP_RD;
        end else begin
          state_d = S_DOWN_RD;
        end
      end
      S_UP_RD: begin
        if (stat_i.pos_zero) begin
          state_d = S_WRITE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PARENT;
          state_d      = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        priority if (stat_i.up_better) begin
          cmd_o.up_move = 1'b1;
          allow_down_d  = 1'b0;
          state_d       = S_UP_RD;
        end else if (allow_down_q) begin
          allow_down_d = 1'b0;
          state_d      = S_DOWN_RD;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_DOWN_RD: begin
        if (!stat_i.left_in_range) begin
          state_d = S_WRITE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
          state_d      = S_DOWN_RL;
        end
      end
      S_DOWN_RL: begin
        cmd_o.latch_left = 1'b1;
        cmd_o.rd_en      = 1'b1;
        cmd_o.rd_sel     = RD_RIGHT;
        state_d          = S_DOWN_CMP;
      end
      S_DOWN_CMP: begin
        if (stat_i.best_child) begin
          cmd_o.down_move = 1'b1;
          state_d         = S_DOWN_RD;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write_cur = 1'b1;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/bhpq_dp.sv =====
// ----------------------------------------------------------------------------
// Heap datapath
// Key store, operation registers, index arithmetic, compares and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bhpq_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 largest_first_i,
  input  bhpq_pkg::cmd_t                       cmd_i,
  output bhpq_pkg::stat_t                      stat_o,
  input  logic [bhpq_pkg::OP_W-1:0]            in_opcode_i,
  input  logic signed [bhpq_pkg::KEY_BITS-1:0] in_key_i,
  input  logic [bhpq_pkg::IDX_W-1:0]           in_slot_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [bhpq_pkg::KEY_BITS-1:0] out_value_o,
  output logic [bhpq_pkg::STATUS_W-1:0]        out_status_o,
  output logic [bhpq_pkg::CNT_W-1:0]           out_count_o
);
  import bhpq_pkg::*;

  logic signed [KEY_BITS-1:0] heap_mem [CAPACITY];
  logic signed [KEY_BITS-1:0] rd_data_q;

  opcode_e                    op_q;
  logic signed [KEY_BITS-1:0] key_q;
  logic [IDX_W-1:0]           slot_q;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [IDX_W-1:0]           pos_q, pos_d;
  logic signed [KEY_BITS-1:0] cur_q, val_q, best_q;
  logic                       best_left_q;
  status_e                    status_q;
  logic                       out_valid_q;

  logic [IDX_W-1:0]           target_idx, last_idx, parent_idx, rd_addr, wr_addr;
  logic [CNT_W-1:0]           cnt_m1;
  logic [CH_W-1:0]            left_ext, right_ext, cnt_ext;
  logic                       right_in_range, right_better, left_better;
  logic                       wr_en;
  logic signed [KEY_BITS-1:0] wr_data;

  assign target_idx = (op_q == OP_EXTRACT) ? '0 : slot_q;
  assign cnt_m1     = cnt_q - CNT_W'(1);
  assign last_idx   = cnt_m1[IDX_W-1:0];
  assign parent_idx = IDX_W'((pos_q - IDX_W'(1)) >> 1);
  assign left_ext   = {1'b0, pos_q, 1'b1};
  assign right_ext  = left_ext + CH_W'(1);
  assign cnt_ext    = CH_W'(cnt_q);

  assign right_in_range = right_ext < cnt_ext;
  assign left_better    = ranks_above(rd_data_q, cur_q, largest_first_i);
  assign right_better   = right_in_range && ranks_above(rd_data_q, best_q, largest_first_i);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_TARGET: rd_addr = target_idx;
      RD_LAST:   rd_addr = last_idx;
      RD_PARENT: rd_addr = parent_idx;
      RD_LEFT:   rd_addr = left_ext[IDX_W-1:0];
      RD_RIGHT:  rd_addr = right_ext[IDX_W-1:0];
      default:   rd_addr = target_idx;
    endcase
  end

  // The sifting key stays in cur_q; passed entries move, then cur_q is written.
  assign wr_en   = cmd_i.up_move || cmd_i.down_move || cmd_i.write_cur;
  assign wr_addr = pos_q;
  always_comb begin
    priority if (cmd_i.up_move) begin
      wr_data = rd_data_q;
    end else if (cmd_i.down_move) begin
      wr_data = right_better ? rd_data_q : best_q;
    end else begin
      wr_data = cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= heap_mem[rd_addr];
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    priority if (cmd_i.push_start) begin
      cnt_d = cnt_q + CNT_W'(1);
      pos_d = cnt_q[IDX_W-1:0];
    end else if (cmd_i.start_take) begin
      pos_d = target_idx;
    end else if (cmd_i.take_value) begin
      cnt_d = cnt_m1;
    end else if (cmd_i.up_move) begin
      pos_d = parent_idx;
    end else if (cmd_i.down_move) begin
      pos_d = right_better ? right_ext[IDX_W-1:0] : left_ext[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      op_q        <= OP_NOP;
      status_q    <= ST_OK;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load_in) begin
        op_q     <= opcode_e'(in_opcode_i);
        status_q <= ST_OK;
      end else if (cmd_i.set_status) begin
        status_q <= cmd_i.status_code;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.load_in) begin
      key_q  <= in_key_i;
      slot_q <= in_slot_i;
      val_q  <= '0;
    end else if (cmd_i.take_value) begin
      val_q <= rd_data_q;
    end
    if (cmd_i.push_start) begin
      cur_q <= key_q;
    end else if (cmd_i.take_cur) begin
      cur_q <= rd_data_q;
    end
    if (cmd_i.latch_left) begin
      best_q      <= left_better ? rd_data_q : cur_q;
      best_left_q <= left_better;
    end
    if (cmd_i.load_out) begin
      out_value_o  <= val_q;
      out_status_o <= status_q;
      out_count_o  <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.op            = op_q;
  assign stat_o.full          = cnt_q >= CNT_W'(CAPACITY);
  assign stat_o.empty         = cnt_q == '0;
  assign stat_o.slot_bad      = CNT_W'(slot_q) >= cnt_q;
  assign stat_o.pos_is_last   = CNT_W'(pos_q) == cnt_m1;
  assign stat_o.pos_zero      = pos_q == '0;
  assign stat_o.left_in_range = left_ext < cnt_ext;
  assign stat_o.up_better     = ranks_above(cur_q, rd_data_q, largest_first_i);
  assign stat_o.best_child    = right_better || best_left_q;
  assign stat_o.out_free      = !out_valid_q || out_ready_i;

endmodule

// ===== rtl/binary_heap_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// Binary heap priority queue
// This block keeps up to 128 signed 32-bit keys in a binary heap held in an
// on-chip memory with one read and one write port. Each input item is a push,
// an extract of the top key, a removal at a given heap slot, or a no-op, and
// each item produces exactly one result item with the key taken out (zero for
// a push), a status code and the number of keys held afterwards. The register
// largest_first at byte address 0 selects whether the smallest or the largest
// key sits on top; changing it does not reorder stored keys. Items are worked
// on one at a time, and the time per item is set by the sift walk through the
// single memory read port. A push climbs level by level until it stops below
// the root or reaches it. An extract walks down level by level until a compare
// ends the walk above a leaf or it reaches one. A remove away from the root
// first tries to climb, then either climbs level by level or walks down as an
// extract does. A finished result sits in an output register, so the next item
// is taken while it waits; only a result that is still waiting when the next
// one is ready stalls the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_heap_priority_queue_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  bhpq_in_if.sink                           item_in_i,
  bhpq_out_if.source                        item_out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bhpq_pkg::PADDR_W-1:0]      paddr,
  input  logic [bhpq_pkg::PDATA_W-1:0]      pwdata,
  output logic [bhpq_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import bhpq_pkg::*;

  // Configuration register. Writes complete in the access phase; the port
  // never stalls. The register index is the word address (paddr above bit 1).
  logic  largest_first_q;
  logic  cfg_wr;
  logic  reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[PADDR_W-1];
  assign cfg_wr    = psel && penable && pwrite && (reg_index == REG_LARGEST_FIRST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      largest_first_q <= 1'b0;
    end else if (cfg_wr) begin
      largest_first_q <= pwdata[0];
    end
  end

  // Reads return the register; unused addresses read as zero.
  always_comb begin
    prdata = '0;
    if (reg_index == REG_LARGEST_FIRST) begin
      prdata[0] = largest_first_q;
    end
  end

  // The controller sequences each item; the datapath owns the key store,
  // the entry count and the result register.
  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  bhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bhpq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .largest_first_i (largest_first_q),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_opcode_i     (item_in_i.opcode),
    .in_key_i        (item_in_i.key),
    .in_slot_i       (item_in_i.slot),
    .out_valid_o     (item_out_o.valid),
    .out_ready_i     (item_out_o.ready),
    .out_value_o     (item_out_o.value),
    .out_status_o    (item_out_o.status),
    .out_count_o     (item_out_o.count)
  );

  assign item_in_i.ready = in_ready;

endmodule
